[rtl/core/mau_pkg.sv]
// Package with the shared widths, codes and types of the modular arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package mau_pkg;
   localparam int OPERAND_WIDTH = 32;
   localparam int VALUE_W = 31;
   localparam int SH_W = (OPERAND_WIDTH > VALUE_W) ? OPERAND_WIDTH : VALUE_W + 1;
   localparam int CNT_W = $clog2(SH_W + 1);
   localparam int REQ_DATA_W = ((2 * OPERAND_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VALUE_W + 7) / 8) * 8;
   localparam logic [VALUE_W-1:0] MODULUS_RESET = 31'd1000000007;

   localparam logic [2:0] CMD_REDUCE = 3'd0;
   localparam logic [2:0] CMD_ADD    = 3'd1;
   localparam logic [2:0] CMD_SUB    = 3'd2;
   localparam logic [2:0] CMD_MUL    = 3'd3;
   localparam logic [2:0] CMD_DIV    = 3'd4;
   localparam logic [2:0] CMD_POW    = 3'd5;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_NO_INV = 1'b1;

   typedef struct packed {
      logic [VALUE_W-1:0] acc;
      logic [VALUE_W-1:0] n;
      logic [VALUE_W-1:0] addend;
      logic               add_en;
   } step_in_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               flag;
   } step_out_type;
endpackage
`default_nettype wire

[rtl/core/mau_modstep.sv]
// Shared step unit: value = (2*acc + add_en*addend) mod n, with a wrap flag.
`timescale 1ns / 1ps
`default_nettype none
module mau_modstep import mau_pkg::*; (
   input  step_in_type  step_in,
   output step_out_type step_out
);
   logic [VALUE_W:0] dbl;
   logic [VALUE_W:0] nn;
   logic [VALUE_W:0] t;
   logic [VALUE_W:0] s;
   logic             f1;
   logic             f2;

   always_comb begin
      nn  = {1'b0, step_in.n};
      dbl = {step_in.acc, 1'b0};
      f1  = (dbl >= nn);
      t   = f1 ? dbl - nn : dbl;
      s   = t + (step_in.add_en ? {1'b0, step_in.addend} : '0);
      f2  = (s >= nn);
      step_out.value = f2 ? VALUE_W'(s - nn) : VALUE_W'(s);
      step_out.flag  = f1 | f2;
   end
endmodule
`default_nettype wire

[rtl/core/modular_arithmetic_unit.sv]
// Top level of the modular arithmetic unit: sequencer around one shared step unit.
//
//   channel | direction | contents
//   req_    | in        | tdata: operand_a, operand_b; tuser: command
//   rsp_    | out       | tdata: result (zero padded); tuser: status
//   csr_    | in        | modulus write data
//
// Each request with a used command and a modulus of at least two runs on one shared
// double-and-add-mod step unit, one bit per cycle. Reduce, add and subtract reduce both operands;
// multiply adds one multiply pass. Power squares once per exponent bit, multiplying first for a set bit.
// Divide runs extended Euclid, a division and a multiply per quotient step, then one multiply.
// Reset is synchronous and restores the modulus to 1000000007.
// A result waits in the output register; a later one finishing meanwhile stalls the unit.
`timescale 1ns / 1ps
`default_nettype none
module modular_arithmetic_unit import mau_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Bits from the lowest up: operand_a, operand_b.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Bits from the lowest up: command.
   input  wire logic [2:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Bits from the lowest up: result, then zero fill.
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // Bits from the lowest up: status.
   output logic                       rsp_tuser,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [VALUE_W-1:0]    csr_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_RED_A, S_FIX_A, S_RED_B, S_FIX_B, S_MUL, S_FIN_MUL,
      S_EU_DIV, S_EU_SUB, S_EU_END, S_POW_BIT, S_POW_ACC, S_POW_SQ, S_FINISH
   } state_type;

   state_type                 state_ff, ret_ff;
   logic [VALUE_W-1:0]        modulus_ff;
   logic [2:0]                cmd_ff;
   logic [OPERAND_WIDTH-1:0]  a_ff, b_ff;
   logic [VALUE_W-1:0]        acc_ff, x_ff, ra_ff, rb_ff;
   logic [SH_W-1:0]           sh_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [VALUE_W-1:0]        r0_ff, r1_ff, rt_ff, t0_ff, t1_ff, q_ff;
   logic [OPERAND_WIDTH-1:0]  e_ff;
   logic [VALUE_W-1:0]        base_ff, pacc_ff, res_ff;
   logic                      status_ff;
   logic                      rsp_valid_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic                      rsp_user_ff;

   step_in_type               step_in;
   step_out_type              step_out;

   logic [OPERAND_WIDTH-1:0]  sel_op, mag;
   logic                      neg;
   logic [VALUE_W-1:0]        fixed;
   logic [VALUE_W:0]          sum;
   logic [VALUE_W-1:0]        add_res, sub_res, tt;
   logic [VALUE_W-1:0]        q_next;
   logic                      last;

   mau_modstep u_step (.step_in(step_in), .step_out(step_out));

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Operand being reduced and its sign; magnitude of operand B (also the power exponent).
   always_comb begin
      sel_op = (state_ff == S_RED_A || state_ff == S_FIX_A) ? a_ff : b_ff;
      neg    = sel_op[OPERAND_WIDTH-1];
      mag    = b_ff[OPERAND_WIDTH-1] ? OPERAND_WIDTH'(-b_ff) : b_ff;
      fixed  = (neg && acc_ff != '0) ? modulus_ff - acc_ff : acc_ff;
      sum    = {1'b0, ra_ff} + {1'b0, rb_ff};
      add_res = (sum >= {1'b0, modulus_ff}) ? VALUE_W'(sum - {1'b0, modulus_ff})
                                            : VALUE_W'(sum);
      // The subtract command runs in the state after FIX_B, where rb_ff is final.
      sub_res = (ra_ff >= rb_ff) ? ra_ff - rb_ff : VALUE_W'(sum - {1'b0, rb_ff} - {1'b0, rb_ff}
                + {1'b0, modulus_ff});
      // New Bezout coefficient: t0 - q*t1 mod M, q*t1 sits in acc_ff.
      tt     = (t0_ff >= acc_ff) ? t0_ff - acc_ff : VALUE_W'({1'b0, t0_ff}
               + {1'b0, modulus_ff} - {1'b0, acc_ff});
      q_next = {q_ff[VALUE_W-2:0], step_out.flag};
      last   = (cnt_ff == CNT_W'(1));
   end

   // The step unit works against the modulus, except while Euclid divides by r1.
   always_comb begin
      step_in.acc    = acc_ff;
      step_in.n      = (state_ff == S_EU_DIV) ? r1_ff : modulus_ff;
      step_in.addend = (state_ff == S_MUL) ? x_ff : VALUE_W'(1);
      step_in.add_en = sh_ff[SH_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         modulus_ff   <= MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) modulus_ff <= csr_data;
         // The finish state refills the output register itself.
         if (rsp_valid_ff && rsp_tready && state_ff != S_FINISH) rsp_valid_ff <= 1'b0;

         unique case (state_ff) inside
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff <= req_tuser;
                  a_ff   <= req_tdata[OPERAND_WIDTH-1:0];
                  b_ff   <= req_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
                  res_ff    <= '0;
                  status_ff <= STATUS_OK;
                  // A modulus below two or an unused command gives zero at once.
                  if (modulus_ff < VALUE_W'(2) || req_tuser > CMD_POW) begin
                     state_ff <= S_FINISH;
                  end else begin
                     state_ff <= S_RED_A;
                     acc_ff   <= '0;
                     cnt_ff   <= CNT_W'(OPERAND_WIDTH);
                     sh_ff    <= SH_W'(req_tdata[OPERAND_WIDTH-1] ?
                                 OPERAND_WIDTH'(-req_tdata[OPERAND_WIDTH-1:0]) :
                                 req_tdata[OPERAND_WIDTH-1:0]) << (SH_W - OPERAND_WIDTH);
                  end
               end
            end
            S_RED_A, S_RED_B: begin
               acc_ff <= step_out.value;
               sh_ff  <= sh_ff << 1;
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (last) state_ff <= (state_ff == S_RED_A) ? S_FIX_A : S_FIX_B;
            end
            S_FIX_A: begin
               ra_ff    <= fixed;
               acc_ff   <= '0;
               cnt_ff   <= CNT_W'(OPERAND_WIDTH);
               sh_ff    <= SH_W'(mag) << (SH_W - OPERAND_WIDTH);
               state_ff <= S_RED_B;
            end
            S_FIX_B: begin
               rb_ff <= fixed;
               case (cmd_ff) inside
                  CMD_REDUCE: begin
                     res_ff   <= ra_ff;
                     state_ff <= S_FIN_MUL;
                  end
                  CMD_ADD, CMD_SUB: begin
                     // Finished in the dispatch below, once rb_ff holds.
                     state_ff <= S_EU_END;
                  end
                  CMD_MUL: begin
                     acc_ff   <= '0;
                     x_ff     <= ra_ff;
                     sh_ff    <= SH_W'({fixed, 1'b0}) << (SH_W - VALUE_W - 1);
                     cnt_ff   <= CNT_W'(VALUE_W);
                     ret_ff   <= S_FIN_MUL;
                     state_ff <= S_MUL;
                  end
                  CMD_DIV: begin
                     if (fixed == '0) begin
                        status_ff <= STATUS_NO_INV;
                        state_ff  <= S_FINISH;
                     end else begin
                        r0_ff    <= modulus_ff;
                        r1_ff    <= fixed;
                        t0_ff    <= '0;
                        t1_ff    <= VALUE_W'(1);
                        q_ff     <= '0;
                        acc_ff   <= '0;
                        sh_ff    <= SH_W'({modulus_ff, 1'b0}) << (SH_W - VALUE_W - 1);
                        cnt_ff   <= CNT_W'(VALUE_W);
                        state_ff <= S_EU_DIV;
                     end
                  end
                  default: begin
                     e_ff     <= mag;
                     base_ff  <= ra_ff;
                     pacc_ff  <= VALUE_W'(1);
                     state_ff <= S_POW_BIT;
                  end
               endcase
            end
            S_MUL: begin
               acc_ff <= step_out.value;
               sh_ff  <= sh_ff << 1;
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (last) state_ff <= ret_ff;
            end
            S_FIN_MUL: begin
               // Reduce keeps the value already in res_ff.
               if (cmd_ff != CMD_REDUCE) res_ff <= acc_ff;
               state_ff <= S_FINISH;
            end
            S_EU_DIV: begin
               q_ff <= q_next;
               if (last) begin
                  rt_ff    <= step_out.value;
                  acc_ff   <= '0;
                  x_ff     <= t1_ff;
                  sh_ff    <= SH_W'({q_next, 1'b0}) << (SH_W - VALUE_W - 1);
                  cnt_ff   <= CNT_W'(VALUE_W);
                  ret_ff   <= S_EU_SUB;
                  state_ff <= S_MUL;
               end else begin
                  acc_ff <= step_out.value;
                  sh_ff  <= sh_ff << 1;
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            S_EU_SUB: begin
               r0_ff <= r1_ff;
               r1_ff <= rt_ff;
               t0_ff <= t1_ff;
               t1_ff <= tt;
               if (rt_ff == '0) begin
                  state_ff <= S_EU_END;
               end else begin
                  q_ff     <= '0;
                  acc_ff   <= '0;
                  sh_ff    <= SH_W'({r1_ff, 1'b0}) << (SH_W - VALUE_W - 1);
                  cnt_ff   <= CNT_W'(VALUE_W);
                  state_ff <= S_EU_DIV;
               end
            end
            S_EU_END: begin
               // Shared by add and subtract (operands final) and the end of Euclid.
               if (cmd_ff == CMD_ADD) begin
                  res_ff   <= add_res;
                  state_ff <= S_FINISH;
               end else if (cmd_ff == CMD_SUB) begin
                  res_ff   <= sub_res;
                  state_ff <= S_FINISH;
               end else if (r0_ff == VALUE_W'(1)) begin
                  acc_ff   <= '0;
                  x_ff     <= ra_ff;
                  sh_ff    <= SH_W'({t0_ff, 1'b0}) << (SH_W - VALUE_W - 1);
                  cnt_ff   <= CNT_W'(VALUE_W);
                  ret_ff   <= S_FIN_MUL;
                  state_ff <= S_MUL;
               end else begin
                  status_ff <= STATUS_NO_INV;
                  state_ff  <= S_FINISH;
               end
            end
            S_POW_BIT: begin
               acc_ff <= '0;
               cnt_ff <= CNT_W'(VALUE_W);
               if (e_ff == '0) begin
                  res_ff   <= pacc_ff;
                  state_ff <= S_FINISH;
               end else if (e_ff[0]) begin
                  x_ff     <= pacc_ff;
                  sh_ff    <= SH_W'({base_ff, 1'b0}) << (SH_W - VALUE_W - 1);
                  ret_ff   <= S_POW_ACC;
                  state_ff <= S_MUL;
               end else begin
                  x_ff     <= base_ff;
                  sh_ff    <= SH_W'({base_ff, 1'b0}) << (SH_W - VALUE_W - 1);
                  ret_ff   <= S_POW_SQ;
                  state_ff <= S_MUL;
               end
            end
            S_POW_ACC: begin
               pacc_ff  <= acc_ff;
               acc_ff   <= '0;
               x_ff     <= base_ff;
               sh_ff    <= SH_W'({base_ff, 1'b0}) << (SH_W - VALUE_W - 1);
               cnt_ff   <= CNT_W'(VALUE_W);
               ret_ff   <= S_POW_SQ;
               state_ff <= S_MUL;
            end
            S_POW_SQ: begin
               base_ff  <= acc_ff;
               e_ff     <= e_ff >> 1;
               state_ff <= S_POW_BIT;
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= RSP_DATA_W'(res_ff);
                  rsp_user_ff  <= status_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[rtl/core/mau_checker.sv]
// Port checker for the modular arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mau_checker import mau_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);
   // A held result keeps its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("held response changed");

   // A failed inverse always reports a zero result.
   a_noinv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("no-inverse status with nonzero result");

   // One request at a time: after an accept the unit is busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // Reset leaves no response pending.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");
endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the modular arithmetic unit: directed table, then random streams.
`timescale 1ns / 1ps
module testbench;
   import mau_pkg::*;

   // Command codes beyond the package's list; the block must answer them with zero.
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam int CYCLE_LIMIT = 30000000;
   localparam int ITEMS_PER_MODULUS = 225;
   localparam int LONG_HOLD_CYCLES = 5000;

   typedef struct packed {
      logic [VALUE_W-1:0] result;
      logic               status;
   } answer_type;

   typedef struct {
      logic [2:0]  cmd;
      logic [31:0] a;
      logic [31:0] b;
      bit          known;
      logic [30:0] result;
      logic        status;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [VALUE_W-1:0] csr_data = '0;

   modular_arithmetic_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   answer_type pending_answers[$];
   logic [VALUE_W-1:0] modulus_now = MODULUS_RESET;
   int send_idle_pct = 36;
   int recv_idle_pct = 74;
   int mismatches = 0;
   int answers_seen = 0;
   int requests_sent = 0;
   int cycle_count = 0;
   int hold_ticket = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // Computes the answer the block owes for one request under the given modulus.
   function automatic answer_type modular_answer(input logic [2:0] cmd, input logic [31:0] a,
                                                 input logic [31:0] b, input logic [30:0] mreg);
      longint m, ra, rb, r0, r1, t0, t1, q, tmp, acc, base;
      longint unsigned e;
      answer_type ans;
      m = (mreg < 2) ? 64'sd1 : longint'(mreg);
      ra = longint'($signed(a)) % m;
      if (ra < 0) ra += m;
      rb = longint'($signed(b)) % m;
      if (rb < 0) rb += m;
      ans = '0;
      case (cmd)
         CMD_REDUCE: ans.result = VALUE_W'(ra);
         CMD_ADD:    ans.result = VALUE_W'((ra + rb) % m);
         CMD_SUB:    ans.result = VALUE_W'((ra + m - rb) % m);
         CMD_MUL:    ans.result = VALUE_W'((ra * rb) % m);
         CMD_DIV: begin
            if (m != 1) begin
               r0 = m; r1 = rb; t0 = 0; t1 = 1;
               while (r1 != 0) begin
                  q = r0 / r1;
                  tmp = r0 - q * r1; r0 = r1; r1 = tmp;
                  tmp = t0 - q * t1; t0 = t1; t1 = tmp;
               end
               if (rb == 0 || r0 != 1) begin
                  ans.status = STATUS_NO_INV;
               end else begin
                  t0 = t0 % m;
                  if (t0 < 0) t0 += m;
                  ans.result = VALUE_W'((ra * t0) % m);
               end
            end
         end
         CMD_POW: begin
            // A negative exponent counts by its magnitude.
            e = ($signed(b) < 0) ? longint'(-longint'($signed(b))) : longint'(b);
            acc = 1 % m;
            base = ra;
            while (e != 0) begin
               if (e[0]) acc = (acc * base) % m;
               base = (base * base) % m;
               e >>= 1;
            end
            ans.result = VALUE_W'(acc);
         end
         default: ans = '0;
      endcase
      return ans;
   endfunction

   // Offers one request, idling first at the current rate, and books its answer on acceptance.
   task automatic offer_request(input logic [2:0] cmd, input logic [31:0] a, input logic [31:0] b,
                                input bit known, input answer_type typed);
      answer_type booked;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {b, a};
      req_tuser = cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      booked = known ? typed : modular_answer(cmd, a, b, modulus_now);
      pending_answers = {pending_answers, booked};
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_tvalid = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   task automatic write_modulus(input logic [VALUE_W-1:0] value);
      csr_valid = 1'b1;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      modulus_now = value;
      @(negedge clock);
      csr_valid = 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: case ($urandom_range(0, 6))
               0: v = 32'h0000_0000;
               1: v = 32'h0000_0001;
               2: v = 32'hFFFF_FFFF;
               3: v = 32'h7FFF_FFFF;
               4: v = 32'h8000_0000;
               5: v = {1'b0, modulus_now} - 32'd1;
               default: v = {1'b0, modulus_now};
            endcase
         1: v = $urandom_range(0, 200) - 100;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Response sink: random backpressure, plus a long hold whenever the ticket moves.
   always @(negedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Every accepted response is compared against the oldest booked answer.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response result=%0d status=%0d",
                                           rsp_tdata, rsp_tuser);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata !== RSP_DATA_W'(want.result) || rsp_tuser !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected result=%0d status=%0d, got result=%0d status=%0d",
                           want.result, want.status, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL modular_arithmetic_unit");
         $finish;
      end
   end

   // Directed vectors; typed answers assume the reset modulus 1000000007.
   vector_type directed[] = '{
      '{CMD_REDUCE, 32'h0000_0000, 32'h1234_5678, 1, 31'd0, STATUS_OK},
      '{CMD_REDUCE, 32'hFFFF_FFFF, 32'h0000_0000, 1, 31'd1000000006, STATUS_OK},
      '{CMD_REDUCE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 31'd147483633, STATUS_OK},
      '{CMD_REDUCE, 32'h8000_0000, 32'h8000_0000, 1, 31'd852516373, STATUS_OK},
      '{CMD_ADD,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 31'd0, STATUS_OK},
      '{CMD_ADD,    32'h8000_0000, 32'hFFFF_FFFF, 0, 31'd0, STATUS_OK},
      '{CMD_SUB,    32'h0000_0000, 32'h0000_0001, 1, 31'd1000000006, STATUS_OK},
      '{CMD_SUB,    32'h8000_0000, 32'h7FFF_FFFF, 0, 31'd0, STATUS_OK},
      '{CMD_MUL,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 31'd1, STATUS_OK},
      '{CMD_MUL,    32'h7FFF_FFFF, 32'h8000_0000, 0, 31'd0, STATUS_OK},
      '{CMD_DIV,    32'h0000_0005, 32'h0000_0000, 1, 31'd0, STATUS_NO_INV},
      '{CMD_DIV,    32'h0000_0007, 32'h3B9A_CA07, 1, 31'd0, STATUS_NO_INV},
      '{CMD_DIV,    32'h0000_0006, 32'h0000_0003, 1, 31'd2, STATUS_OK},
      '{CMD_DIV,    32'h8000_0000, 32'h7FFF_FFFF, 0, 31'd0, STATUS_OK},
      '{CMD_DIV,    32'h0000_0001, 32'hFFFF_FFFF, 1, 31'd1000000006, STATUS_OK},
      '{CMD_POW,    32'h0000_0000, 32'h0000_0000, 1, 31'd1, STATUS_OK},
      '{CMD_POW,    32'h1234_5678, 32'h0000_0000, 1, 31'd1, STATUS_OK},
      '{CMD_POW,    32'h0000_0002, 32'hFFFF_FFFD, 1, 31'd8, STATUS_OK},
      '{CMD_POW,    32'hFFFF_FFFF, 32'h8000_0000, 0, 31'd0, STATUS_OK},
      '{CMD_POW,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 31'd0, STATUS_OK},
      '{CMD_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 31'd0, STATUS_OK},
      '{CMD_SPARE_7, 32'h1234_5678, 32'h0000_0001, 1, 31'd0, STATUS_OK}
   };

   // Modulus settings for the random phases: extremes, composites and the degenerate ones.
   logic [VALUE_W-1:0] moduli[8] = '{31'h7FFF_FFFF, 31'd2, 31'd1000, 31'd1, 31'd0,
                                     31'd97, 31'd1000000007, 31'd0};

   initial begin
      answer_type typed;
      logic [2:0] cmd;
      logic [31:0] a;
      logic [31:0] b;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed pass under the reset modulus.
      foreach (directed[i]) begin
         typed.result = directed[i].result;
         typed.status = directed[i].status;
         offer_request(directed[i].cmd, directed[i].a, directed[i].b, directed[i].known, typed);
      end
      wait_for_drain();

      moduli[7] = VALUE_W'($urandom_range(3, 32'h7FFF_FFFF));
      foreach (moduli[s]) begin
         // Idle pattern: receiver-heavy gaps, then sender-heavy, then none at all.
         if (s < 3) begin
            send_idle_pct = 36; recv_idle_pct = 74;
         end else if (s < 6) begin
            send_idle_pct = 74; recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         write_modulus(moduli[s]);
         for (int n = 0; n < ITEMS_PER_MODULUS; n++) begin
            // Park the receiver mid-phase while requests keep coming, to back the block up.
            if (n == 40 && (s == 1 || s == 6)) hold_ticket++;
            cmd = ($urandom_range(0, 99) < 4) ? (($urandom_range(0, 1) == 0) ? CMD_SPARE_6
                                                                            : CMD_SPARE_7)
                                              : 3'($urandom_range(0, 5));
            a = pick_operand();
            b = pick_operand();
            // Most exponents stay short to keep the run length reasonable.
            if (cmd == CMD_POW && $urandom_range(0, 7) != 0) b = $urandom_range(0, 600) - 300;
            offer_request(cmd, a, b, 0, '0);
         end
         // Sender pauses here until every booked answer is back.
         wait_for_drain();
      end

      repeat (200) @(negedge clock);
      $display("ran %0d requests over %0d modulus settings, %0d responses checked",
               requests_sent, 9, answers_seen);
      $display("mismatches: %0d, answers still owed: %0d", mismatches, pending_answers.size());
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("PASS modular_arithmetic_unit");
      end else begin
         $display("FAIL modular_arithmetic_unit");
      end
      $finish;
   end
endmodule
